### hdl/ece_pkg.sv
// Shared constants, types, tables and arithmetic helpers for the easing curve evaluator.
`timescale 1ns / 1ps
`default_nettype none

package ece_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int TAB_ADDR_BITS = 8;
	localparam int TAB_TOP       = 1 << TAB_ADDR_BITS;
	localparam int IDX_W         = TAB_ADDR_BITS + 1;
	localparam int TAB_W         = FRAC_BITS + 2;
	localparam int FRL_W         = FRAC_BITS - TAB_ADDR_BITS;
	localparam int KIND_W        = 5;
	localparam int U_W           = FRAC_BITS + 1;
	localparam int R_W           = FRAC_BITS + 3;
	localparam int V_W           = FRAC_BITS + 4;
	localparam int OUT_W         = FRAC_BITS + 2;
	localparam int TB_W          = FRAC_BITS + 4;
	localparam int BM_W          = FRAC_BITS + 3;
	localparam int EK_W          = 4;
	localparam int SQ_W          = 2 * FRAC_BITS + 3;
	localparam int SQ_STEPS      = FRAC_BITS + 1;
	localparam int SQ_CHUNK      = (SQ_STEPS + 2) / 3;

	localparam int ONE_I = 1 << FRAC_BITS;
	localparam logic [U_W-1:0] ONE  = U_W'(ONE_I);
	localparam logic [U_W-1:0] HALF = U_W'(ONE_I / 2);

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned LN2_Q30     = 64'd744261118;

	localparam logic [TAB_W-1:0] BACK_C1 =
		TAB_W'(((64'd170158 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [TAB_W-1:0] BACK_C3 = BACK_C1 + TAB_W'(ONE_I);

	// bounce segment edges and offsets, in units of 11*y
	localparam logic [TB_W-1:0] BT_4  = TB_W'(4 * ONE_I);
	localparam logic [TB_W-1:0] BT_8  = TB_W'(8 * ONE_I);
	localparam logic [TB_W-1:0] BT_10 = TB_W'(10 * ONE_I);
	localparam logic [TB_W-1:0] BO_12 = TB_W'(6 * ONE_I);
	localparam logic [TB_W-1:0] BO_18 = TB_W'(9 * ONE_I);
	localparam logic [TB_W-1:0] BO_21 = TB_W'(21 * ONE_I / 2);
	localparam logic [FRAC_BITS-1:0] BK_1 = FRAC_BITS'(3 * ONE_I / 4);
	localparam logic [FRAC_BITS-1:0] BK_2 = FRAC_BITS'(15 * ONE_I / 16);
	localparam logic [FRAC_BITS-1:0] BK_3 = FRAC_BITS'(63 * ONE_I / 64);

	localparam logic signed [V_W-1:0] SAT_LO = V_W'(-(ONE_I / 2));
	localparam logic signed [V_W-1:0] SAT_HI = V_W'(3 * ONE_I / 2);

	typedef enum logic [3:0] {
		FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT, FAM_SINE,
		FAM_BOUNCE, FAM_CIRC, FAM_EXPO, FAM_BACK
	} fam_t;

	typedef enum logic [1:0] {FORM_IN, FORM_OUT, FORM_INOUT} form_t;

	typedef struct packed {
		logic  lin;
		fam_t  fam;
		form_t form;
	} kind_t;

	typedef logic [TAB_W-1:0] tab_t [0:TAB_TOP];

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sq_t;

	function automatic tab_t gen_sin();
		tab_t t;
		longint unsigned x, x2, term, ii;
		longint sum;
		for (int i = 0; i <= TAB_TOP; i++) begin
			ii = 64'(i);
			x = (PI_HALF_Q30 * ii + 64'(TAB_TOP / 2)) >> TAB_ADDR_BITS;
			x2 = (x * x + (64'd1 << 29)) >> 30;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			t[i] = TAB_W'((64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
		end
		return t;
	endfunction

	function automatic tab_t gen_exp();
		tab_t t;
		longint unsigned z, term, sum, ii;
		for (int i = 0; i <= TAB_TOP; i++) begin
			ii = 64'(i);
			z = (LN2_Q30 * ii + 64'(TAB_TOP / 2)) >> TAB_ADDR_BITS;
			term = 64'd1 << 30;
			sum = term;
			for (int k = 1; k <= 14; k++) begin
				term = ((term * z) >> 30) / 64'(k);
				sum = sum + term;
			end
			t[i] = TAB_W'((sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
		end
		return t;
	endfunction

	localparam tab_t SIN_TAB = gen_sin();
	localparam tab_t EXP_TAB = gen_exp();

	function automatic kind_t decode_kind(input logic [KIND_W-1:0] k);
		kind_t d;
		logic [3:0] f;
		logic [KIND_W-1:0] rem;
		f = '0;
		for (int i = 1; i < 9; i++) begin
			if (k >= KIND_W'(3 * i + 1)) begin
				f = 4'(i);
			end
		end
		rem = k - KIND_W'(1) - KIND_W'(3 * f);
		d.lin = (k == '0) || (k > KIND_W'(27));
		d.fam = fam_t'(f);
		d.form = form_t'(rem[1:0]);
		return d;
	endfunction

	function automatic logic [U_W-1:0] umul(input logic [U_W-1:0] a, input logic [U_W-1:0] b);
		logic [2*U_W-1:0] p;
		p = (2*U_W)'(a) * (2*U_W)'(b) + (2*U_W)'(HALF);
		return U_W'(p >> FRAC_BITS);
	endfunction

	function automatic logic [TAB_W-1:0] interp(input logic [TAB_W-1:0] e0,
			input logic [TAB_W-1:0] e1, input logic [FRL_W-1:0] frl);
		logic [TAB_W-1:0] d;
		logic [TAB_W+FRAC_BITS-1:0] p;
		d = e1 - e0;
		p = (TAB_W+FRAC_BITS)'(d) * (TAB_W+FRAC_BITS)'({frl, {TAB_ADDR_BITS{1'b0}}})
			+ (TAB_W+FRAC_BITS)'(HALF);
		return e0 + TAB_W'(p >> FRAC_BITS);
	endfunction

	function automatic sq_t sq_step(input sq_t s, input int sh);
		sq_t o;
		logic [SQ_W-1:0] b, t;
		b = SQ_W'(1) << sh;
		t = s.res + b;
		o = s;
		if (s.rem >= t) begin
			o.rem = s.rem - t;
			o.res = (s.res >> 1) + b;
		end else begin
			o.res = s.res >> 1;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

### hdl/easing_curve_evaluator_top.sv
// Easing curve evaluator: pipelined fixed-point evaluation of 28 easing curves.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input beat: kind and ratio are taken at a rising edge where start is high
//   and busy is low. busy is held low, so a beat may be given every cycle.
//   ratio is unsigned with 16 fraction bits; values above 1.0 count as 1.0.
//   kind 0 and kinds 28..31 are linear.
//   Result beat: eased (signed, 16 fraction bits, saturated to -0.5..1.5) is
//   shown for one cycle with done high. Each input beat gives one result beat,
//   in order.
//   Pipeline: seven register stages, s1 to s7. A taken beat is on the result
//   ports while it is held in s7. Throughput is one beat per cycle.
//   The depth is set by the power chain (one multiply per stage up to u^5) and
//   the square root, which runs six, six and then five digits over three stages.
//   Reset clears the stage valid bits only; no result is shown until new beats
//   arrive. The receiver cannot stall; results are never held back.

module easing_curve_evaluator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [ece_pkg::KIND_W-1:0]           kind,
	input  logic [ece_pkg::U_W-1:0]              ratio,
	output logic                                 done,
	output logic signed [ece_pkg::OUT_W-1:0]     eased
);

	localparam int F = ece_pkg::FRAC_BITS;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 0
	ece_pkg::kind_t dec0;
	logic [ece_pkg::U_W-1:0] xc0, u0;
	logic hi0;

	always_comb begin
		dec0 = ece_pkg::decode_kind(kind);
		xc0 = (ratio > ece_pkg::ONE) ? ece_pkg::ONE : ratio;
		hi0 = xc0 >= ece_pkg::HALF;
		case (dec0.form)
			ece_pkg::FORM_IN:    u0 = xc0;
			ece_pkg::FORM_OUT:   u0 = ece_pkg::ONE - xc0;
			ece_pkg::FORM_INOUT: u0 = hi0 ? ((ece_pkg::ONE - xc0) << 1) : (xc0 << 1);
			default:             u0 = xc0;
		endcase
	end

	logic lin_s1, hi_s1;
	ece_pkg::fam_t fam_s1;
	ece_pkg::form_t form_s1;
	logic [ece_pkg::U_W-1:0] x_s1, u_s1;

	// stage 2 logic
	logic [ece_pkg::U_W-1:0] sp, by, eone;
	logic [ece_pkg::IDX_W-1:0] sidx, snxt, eidx, enxt;
	logic [ece_pkg::TB_W-1:0] bt, bm, em;
	logic [F-1:0] bk;
	logic [ece_pkg::TAB_W+ece_pkg::U_W-1:0] bcp;

	always_comb begin
		sp = ece_pkg::ONE - u_s1;
		sidx = sp[F:ece_pkg::FRL_W];
		snxt = (sidx == ece_pkg::IDX_W'(ece_pkg::TAB_TOP)) ? sidx : sidx + 1'b1;

		by = ece_pkg::ONE - u_s1;
		bt = ece_pkg::TB_W'(by) * ece_pkg::TB_W'(11);
		if (bt < ece_pkg::BT_4) begin
			bm = bt;
			bk = '0;
		end else if (bt < ece_pkg::BT_8) begin
			bm = (bt >= ece_pkg::BO_12) ? bt - ece_pkg::BO_12 : ece_pkg::BO_12 - bt;
			bk = ece_pkg::BK_1;
		end else if (bt < ece_pkg::BT_10) begin
			bm = (bt >= ece_pkg::BO_18) ? bt - ece_pkg::BO_18 : ece_pkg::BO_18 - bt;
			bk = ece_pkg::BK_2;
		end else begin
			bm = (bt >= ece_pkg::BO_21) ? bt - ece_pkg::BO_21 : ece_pkg::BO_21 - bt;
			bk = ece_pkg::BK_3;
		end

		bcp = (ece_pkg::TAB_W+ece_pkg::U_W)'(ece_pkg::BACK_C3)
			* (ece_pkg::TAB_W+ece_pkg::U_W)'(u_s1)
			+ (ece_pkg::TAB_W+ece_pkg::U_W)'(ece_pkg::HALF);

		em = ece_pkg::TB_W'(ece_pkg::ONE - u_s1) * ece_pkg::TB_W'(10);
		eone = ece_pkg::ONE - {1'b0, em[F-1:0]};
		eidx = eone[F:ece_pkg::FRL_W];
		enxt = (eidx == ece_pkg::IDX_W'(ece_pkg::TAB_TOP)) ? eidx : eidx + 1'b1;
	end

	logic lin_s2, hi_s2, ez_s2;
	ece_pkg::fam_t fam_s2;
	ece_pkg::form_t form_s2;
	logic [ece_pkg::U_W-1:0] x_s2, u_s2, p2_s2;
	logic [ece_pkg::TAB_W-1:0] se0_s2, se1_s2, ee0_s2, ee1_s2, bc_s2;
	logic [ece_pkg::FRL_W-1:0] sfr_s2, efr_s2;
	logic [ece_pkg::BM_W-1:0] bm_s2;
	logic [F-1:0] bk_s2;
	logic [ece_pkg::EK_W-1:0] ek_s2;

	// stage 3 logic
	logic [ece_pkg::TAB_W-1:0] sv, ev;
	logic [2*ece_pkg::BM_W-1:0] bsq;
	logic [ece_pkg::R_W-1:0] bb;
	logic [ece_pkg::R_W-1:0] es, eo;

	always_comb begin
		sv = ece_pkg::interp(se0_s2, se1_s2, sfr_s2);
		bsq = (2*ece_pkg::BM_W)'(bm_s2) * (2*ece_pkg::BM_W)'(bm_s2)
			+ ((2*ece_pkg::BM_W)'(1) << (F + 3));
		bb = ece_pkg::R_W'(bsq >> (F + 4)) + ece_pkg::R_W'(bk_s2);
		ev = ece_pkg::interp(ee0_s2, ee1_s2, efr_s2);
		es = ece_pkg::R_W'(ev) + (ece_pkg::R_W'(1) << ek_s2);
		eo = es >> (ek_s2 + 1'b1);
	end

	logic lin_s3, hi_s3;
	ece_pkg::fam_t fam_s3;
	ece_pkg::form_t form_s3;
	logic [ece_pkg::U_W-1:0] x_s3, u_s3, p2_s3, p3_s3, rad_s3;
	logic signed [ece_pkg::R_W-1:0] sin_s3, bnc_s3, bb_s3, exp_s3;

	// stage 4 logic
	logic [ece_pkg::R_W-1:0] bbm;
	logic [ece_pkg::U_W+ece_pkg::R_W-1:0] bkp;
	logic [ece_pkg::R_W-1:0] bkm;
	ece_pkg::sq_t sqa;

	always_comb begin
		bbm = bb_s3[ece_pkg::R_W-1] ? ece_pkg::R_W'(-bb_s3) : ece_pkg::R_W'(bb_s3);
		bkp = (ece_pkg::U_W+ece_pkg::R_W)'(p2_s3) * (ece_pkg::U_W+ece_pkg::R_W)'(bbm)
			+ (ece_pkg::U_W+ece_pkg::R_W)'(ece_pkg::HALF);
		bkm = ece_pkg::R_W'(bkp >> F);
		sqa.rem = ece_pkg::SQ_W'(rad_s3) << F;
		sqa.res = '0;
		for (int j = 0; j < ece_pkg::SQ_CHUNK; j++) begin
			sqa = ece_pkg::sq_step(sqa, 2 * F - 2 * j);
		end
	end

	logic lin_s4, hi_s4;
	ece_pkg::fam_t fam_s4;
	ece_pkg::form_t form_s4;
	logic [ece_pkg::U_W-1:0] x_s4, u_s4, p2_s4, p3_s4, p4_s4;
	logic signed [ece_pkg::R_W-1:0] sin_s4, bnc_s4, back_s4, exp_s4;
	ece_pkg::sq_t sq_s4;

	// stage 5 logic
	ece_pkg::sq_t sqb;

	always_comb begin
		sqb = sq_s4;
		for (int j = ece_pkg::SQ_CHUNK; j < 2 * ece_pkg::SQ_CHUNK; j++) begin
			sqb = ece_pkg::sq_step(sqb, 2 * F - 2 * j);
		end
	end

	logic lin_s5, hi_s5;
	ece_pkg::fam_t fam_s5;
	ece_pkg::form_t form_s5;
	logic [ece_pkg::U_W-1:0] x_s5, p2_s5, p3_s5, p4_s5, p5_s5;
	logic signed [ece_pkg::R_W-1:0] sin_s5, bnc_s5, back_s5, exp_s5;
	ece_pkg::sq_t sq_s5;

	// stage 6 logic
	ece_pkg::sq_t sqc;
	logic [ece_pkg::SQ_W-1:0] root;
	logic signed [ece_pkg::R_W-1:0] circ, rsel;

	always_comb begin
		sqc = sq_s5;
		for (int j = 2 * ece_pkg::SQ_CHUNK; j < ece_pkg::SQ_STEPS; j++) begin
			sqc = ece_pkg::sq_step(sqc, 2 * F - 2 * j);
		end
		root = (sqc.rem > sqc.res) ? sqc.res + 1'b1 : sqc.res;
		circ = $signed(ece_pkg::R_W'(ece_pkg::ONE)) - $signed(ece_pkg::R_W'(root));
		case (fam_s5)
			ece_pkg::FAM_QUAD:   rsel = $signed(ece_pkg::R_W'(p2_s5));
			ece_pkg::FAM_CUBIC:  rsel = $signed(ece_pkg::R_W'(p3_s5));
			ece_pkg::FAM_QUART:  rsel = $signed(ece_pkg::R_W'(p4_s5));
			ece_pkg::FAM_QUINT:  rsel = $signed(ece_pkg::R_W'(p5_s5));
			ece_pkg::FAM_SINE:   rsel = sin_s5;
			ece_pkg::FAM_BOUNCE: rsel = bnc_s5;
			ece_pkg::FAM_CIRC:   rsel = circ;
			ece_pkg::FAM_EXPO:   rsel = exp_s5;
			ece_pkg::FAM_BACK:   rsel = back_s5;
			default:             rsel = $signed(ece_pkg::R_W'(x_s5));
		endcase
	end

	logic lin_s6, hi_s6;
	ece_pkg::form_t form_s6;
	logic [ece_pkg::U_W-1:0] x_s6;
	logic signed [ece_pkg::R_W-1:0] r_s6;

	// stage 7 logic
	logic signed [ece_pkg::V_W-1:0] rv, hv, vv, one_v;
	logic [ece_pkg::R_W-1:0] rm, hm;

	always_comb begin
		one_v = $signed(ece_pkg::V_W'(ece_pkg::ONE));
		rv = ece_pkg::V_W'(r_s6);
		rm = r_s6[ece_pkg::R_W-1] ? ece_pkg::R_W'(-r_s6) : ece_pkg::R_W'(r_s6);
		hm = (rm + 1'b1) >> 1;
		hv = r_s6[ece_pkg::R_W-1] ? -$signed(ece_pkg::V_W'(hm)) : $signed(ece_pkg::V_W'(hm));
		if (lin_s6) begin
			vv = $signed(ece_pkg::V_W'(x_s6));
		end else begin
			case (form_s6)
				ece_pkg::FORM_IN:    vv = rv;
				ece_pkg::FORM_OUT:   vv = one_v - rv;
				ece_pkg::FORM_INOUT: vv = hi_s6 ? one_v - hv : hv;
				default:             vv = rv;
			endcase
		end
		if (vv < ece_pkg::SAT_LO) begin
			vv = ece_pkg::SAT_LO;
		end else if (vv > ece_pkg::SAT_HI) begin
			vv = ece_pkg::SAT_HI;
		end
	end

	logic signed [ece_pkg::OUT_W-1:0] eased_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		lin_s1  <= dec0.lin;
		fam_s1  <= dec0.fam;
		form_s1 <= dec0.form;
		hi_s1   <= hi0;
		x_s1    <= xc0;
		u_s1    <= u0;

		lin_s2  <= lin_s1;
		fam_s2  <= fam_s1;
		form_s2 <= form_s1;
		hi_s2   <= hi_s1;
		x_s2    <= x_s1;
		u_s2    <= u_s1;
		p2_s2   <= ece_pkg::umul(u_s1, u_s1);
		se0_s2  <= ece_pkg::SIN_TAB[sidx];
		se1_s2  <= ece_pkg::SIN_TAB[snxt];
		sfr_s2  <= sp[ece_pkg::FRL_W-1:0];
		bm_s2   <= ece_pkg::BM_W'(bm);
		bk_s2   <= bk;
		bc_s2   <= ece_pkg::TAB_W'(bcp >> F);
		ez_s2   <= (u_s1 == '0);
		ek_s2   <= em[F+ece_pkg::EK_W-1:F];
		ee0_s2  <= ece_pkg::EXP_TAB[eidx];
		ee1_s2  <= ece_pkg::EXP_TAB[enxt];
		efr_s2  <= eone[ece_pkg::FRL_W-1:0];

		lin_s3  <= lin_s2;
		fam_s3  <= fam_s2;
		form_s3 <= form_s2;
		hi_s3   <= hi_s2;
		x_s3    <= x_s2;
		u_s3    <= u_s2;
		p2_s3   <= p2_s2;
		p3_s3   <= ece_pkg::umul(p2_s2, u_s2);
		sin_s3  <= $signed(ece_pkg::R_W'(ece_pkg::ONE)) - $signed(ece_pkg::R_W'(sv));
		bnc_s3  <= $signed(ece_pkg::R_W'(ece_pkg::ONE)) - $signed(bb);
		bb_s3   <= $signed(ece_pkg::R_W'(bc_s2)) - $signed(ece_pkg::R_W'(ece_pkg::BACK_C1));
		exp_s3  <= ez_s2 ? '0 : $signed(eo);
		rad_s3  <= ece_pkg::ONE - p2_s2;

		lin_s4  <= lin_s3;
		fam_s4  <= fam_s3;
		form_s4 <= form_s3;
		hi_s4   <= hi_s3;
		x_s4    <= x_s3;
		u_s4    <= u_s3;
		p2_s4   <= p2_s3;
		p3_s4   <= p3_s3;
		p4_s4   <= ece_pkg::umul(p3_s3, u_s3);
		sin_s4  <= sin_s3;
		bnc_s4  <= bnc_s3;
		back_s4 <= bb_s3[ece_pkg::R_W-1] ? -$signed(bkm) : $signed(bkm);
		exp_s4  <= exp_s3;
		sq_s4   <= sqa;

		lin_s5  <= lin_s4;
		fam_s5  <= fam_s4;
		form_s5 <= form_s4;
		hi_s5   <= hi_s4;
		x_s5    <= x_s4;
		p2_s5   <= p2_s4;
		p3_s5   <= p3_s4;
		p4_s5   <= p4_s4;
		p5_s5   <= ece_pkg::umul(p4_s4, u_s4);
		sin_s5  <= sin_s4;
		bnc_s5  <= bnc_s4;
		back_s5 <= back_s4;
		exp_s5  <= exp_s4;
		sq_s5   <= sqb;

		lin_s6  <= lin_s5;
		form_s6 <= form_s5;
		hi_s6   <= hi_s5;
		x_s6    <= x_s5;
		r_s6    <= rsel;

		eased_s7 <= ece_pkg::OUT_W'(vv);
	end

	assign busy  = 1'b0;
	assign done  = valid_s7;
	assign eased = eased_s7;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("accepted beat did not produce a result after seven cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result beat without a matching input beat");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ece_pkg::V_W'(eased) >= ece_pkg::SAT_LO)
			&& (ece_pkg::V_W'(eased) <= ece_pkg::SAT_HI))
		else $error("eased value outside saturation range");

	a_linear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && lin_s6) |=> (eased == $signed(ece_pkg::OUT_W'($past(x_s6)))))
		else $error("linear curve did not pass the clamped ratio");

endmodule

`default_nettype wire
